// ===== design/backbone_secondary_structure_assign_core_defines.svh =====
// Assertion macros for the secondary structure assignment core
`ifndef BACKBONE_SECONDARY_STRUCTURE_ASSIGN_CORE_DEFINES_SVH
`define BACKBONE_SECONDARY_STRUCTURE_ASSIGN_CORE_DEFINES_SVH
`ifndef ASSERT_OFF
`define BSSA_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define BSSA_ASSERT_NEVER(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);
`else
`define BSSA_ASSERT(lbl, prop, msg)
`define BSSA_ASSERT_NEVER(lbl, cond, msg)
`endif
`endif

// ===== design/bssa_pkg.sv =====
// Shared types, band limits and codes for the secondary structure core
`timescale 1ns / 1ps
package bssa_pkg;

  typedef struct packed {
    logic signed [24:0] x;
    logic signed [24:0] y;
    logic signed [24:0] z;
  } coord_t;

  typedef struct packed {
    logic       clr;
    logic       en;
    logic [1:0] sep;
  } dist_ctl_t;

  typedef enum logic [4:0] {
    ST_LOAD, ST_SHORT,
    ST_D_RDI, ST_D_LDI, ST_D_NEXTK, ST_D_RDJ, ST_D_SQX, ST_D_SQY, ST_D_SQZ,
    ST_D_CMP, ST_D_FIN,
    ST_R_RD0, ST_R_INIT, ST_R_RD, ST_R_EV, ST_R_END,
    ST_F_LD, ST_F_DEC, ST_F_EXA, ST_F_EXA2, ST_F_EXB, ST_F_EXB2, ST_F_CLR, ST_F_NEXT,
    ST_T_RD2, ST_T_RDN, ST_T_CAP,
    ST_O_RD, ST_O_LD, ST_O_WAIT
  } state_t;

  localparam logic [1:0] SSE_COIL   = 2'd0;
  localparam logic [1:0] SSE_HELIX  = 2'd1;
  localparam logic [1:0] SSE_STRAND = 2'd2;

  localparam logic [1:0] STAT_OK    = 2'd0;
  localparam logic [1:0] STAT_SHORT = 2'd1;
  localparam logic [1:0] STAT_DROP  = 2'd2;

  localparam int MIN_RES = 5;
  localparam int ACC_W   = 30;

  // squared band limits in square thousandths, separations 2, 3, 4
  localparam logic [ACC_W-1:0] HELIX_LO2 [3] = '{
    ACC_W'(3350 * 3350), ACC_W'(3080 * 3080), ACC_W'(4270 * 4270)};
  localparam logic [ACC_W-1:0] HELIX_HI2 [3] = '{
    ACC_W'(7550 * 7550), ACC_W'(7280 * 7280), ACC_W'(8470 * 8470)};
  localparam logic [ACC_W-1:0] STRAND_LO2 [3] = '{
    ACC_W'(4680 * 4680), ACC_W'(8980 * 8980), ACC_W'(11580 * 11580)};
  localparam logic [ACC_W-1:0] STRAND_HI2 [3] = '{
    ACC_W'(7520 * 7520), ACC_W'(11820 * 11820), ACC_W'(14420 * 14420)};

  // all six window distances inside one band kind
  function automatic logic window_ok(input logic [5:0] f0, input logic [5:0] f1,
                                     input logic [5:0] f2, input logic strand);
    logic [2:0] a;
    logic [2:0] b;
    logic [2:0] c;
    a = strand ? f0[5:3] : f0[2:0];
    b = strand ? f1[5:3] : f1[2:0];
    c = strand ? f2[5:3] : f2[2:0];
    return a[2] & a[1] & b[1] & a[0] & b[0] & c[0];
  endfunction

endpackage

// ===== design/bssa_coord_mem.sv =====
// Coordinate store: one write port, one registered read port
`timescale 1ns / 1ps
module bssa_coord_mem #(
  parameter int DEPTH = 64,
  parameter int AW    = 6
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  bssa_pkg::coord_t wdata,
  input  logic [AW-1:0]    raddr,
  output bssa_pkg::coord_t rdata
);

  bssa_pkg::coord_t mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== design/bssa_dist_unit.sv =====
// Shared squared-distance accumulator and band compare
`timescale 1ns / 1ps
module bssa_dist_unit (
  input  logic                      clk,
  input  bssa_pkg::dist_ctl_t       ctl,
  input  logic signed [24:0]        a,
  input  logic signed [24:0]        b,
  output logic [1:0]                band
);

  logic [bssa_pkg::ACC_W-1:0] acc_r;
  logic                       far_r;
  logic [25:0]                diff;
  logic [25:0]                mag;
  logic [27:0]                sq;

  assign diff = {a[24], a} - {b[24], b};
  assign mag  = diff[25] ? (~diff + 26'd1) : diff;
  assign sq   = mag[13:0] * mag[13:0];

  // any axis of 16384 or more lies beyond every band
  always_ff @(posedge clk) begin
    if (ctl.clr) begin
      acc_r <= '0;
      far_r <= 1'b0;
    end else if (ctl.en) begin
      if (mag[25:14] != '0) begin
        far_r <= 1'b1;
      end else begin
        acc_r <= acc_r + {2'b00, sq};
      end
    end
  end

  always_comb begin
    band[0] = !far_r && acc_r > bssa_pkg::HELIX_LO2[ctl.sep]
              && acc_r < bssa_pkg::HELIX_HI2[ctl.sep];
    band[1] = !far_r && acc_r > bssa_pkg::STRAND_LO2[ctl.sep]
              && acc_r < bssa_pkg::STRAND_HI2[ctl.sep];
  end

endmodule

// ===== design/backbone_secondary_structure_assign_core.sv =====
// Top level: residue load, band sequencer, run table and result output
// Load: one residue word per cycle while in_ready is high; a residue arrives in one cycle.
// After the last word: distance work (per residue a fetch, then for up to three pairs on the
// shared squarer a partner fetch, one squaring per axis and a compare, a step past the pairs and
// the label write), then the run scan, the run fixes, and the result words, which wait on out_ready.
// Four or fewer residues answer with a single short-status word.
// Reset (rst_n low, synchronous) clears the sequencer, the load count, the overflow flag and output valid.
`timescale 1ns / 1ps
`include "backbone_secondary_structure_assign_core_defines.svh"
module backbone_secondary_structure_assign_core #(
  parameter int MAX_RES  = 64,
  parameter int MAX_RUNS = 32
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic signed [24:0] in_pos_x,
  input  logic signed [24:0] in_pos_y,
  input  logic signed [24:0] in_pos_z,
  input  logic               in_last_residue,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [5:0]         out_residue_index,
  output logic [1:0]         out_sse_code,
  output logic [1:0]         out_status,
  output logic               out_last_result
);

  localparam int IW  = $clog2(MAX_RES);
  localparam int CW  = $clog2(MAX_RES + 1);
  localparam int EW  = CW + 2;
  localparam int RIW = $clog2(MAX_RUNS);
  localparam int RW  = $clog2(MAX_RUNS + 1);

  bssa_pkg::state_t state_r, state_nxt;

  logic [CW-1:0]  cnt_r, n_r, i_r, j_r, a_r, b_r;
  logic           ovf_r;
  logic [1:0]     stat_r;
  logic [1:0]     k_r;
  bssa_pkg::coord_t ci_r;
  logic [5:0]     cur_flags_r, fo1_r, fo2_r;
  logic [1:0]     prev_r, cur_r, h_r, t_r;
  logic [RW-1:0]  ns_r, ne_r, rk_r;

  logic [CW-1:0]  run_starts [MAX_RUNS];
  logic [CW-1:0]  run_ends   [MAX_RUNS];
  logic [1:0]     label_mem  [MAX_RES];
  logic [1:0]     lq;

  logic [5:0]     idx_r;
  logic [1:0]     code_r, ostat_r;
  logic           last_r, ovalid_r;

  // sequencer control and datapath wires
  logic [IW-1:0]  crd_addr;
  bssa_pkg::dist_ctl_t dctl;
  logic           lbl_we;
  logic [IW-1:0]  lbl_waddr, lbl_raddr;
  logic [1:0]     lbl_wdata;
  logic signed [24:0] ua, ub;
  logic [1:0]     band;
  bssa_pkg::coord_t cq;

  // load and index helpers
  logic           in_acc, fits;
  logic [CW-1:0]  n_eff;
  logic [EW-1:0]  i_e, n_e, a_e, b_e, j_e;
  logic [CW-1:0]  jpair;
  logic [1:0]     win_lbl;

  assign in_ready = (state_r == bssa_pkg::ST_LOAD);
  assign in_acc   = in_valid && in_ready;
  assign fits     = cnt_r < CW'(MAX_RES);
  assign n_eff    = fits ? cnt_r + CW'(1) : cnt_r;
  assign i_e      = EW'(i_r);
  assign n_e      = EW'(n_r);
  assign a_e      = EW'(a_r);
  assign b_e      = EW'(b_r);
  assign j_e      = EW'(j_r);
  assign jpair    = i_r + CW'(k_r) + CW'(2);

  assign out_valid         = ovalid_r;
  assign out_residue_index = idx_r;
  assign out_sse_code      = code_r;
  assign out_status        = ostat_r;
  assign out_last_result   = last_r;

  bssa_coord_mem #(.DEPTH(MAX_RES), .AW(IW)) u_coord (
    .clk   (clk),
    .we    (in_acc && fits),
    .waddr (cnt_r[IW-1:0]),
    .wdata ('{x: in_pos_x, y: in_pos_y, z: in_pos_z}),
    .raddr (crd_addr),
    .rdata (cq)
  );

  bssa_dist_unit u_dist (
    .clk  (clk),
    .ctl  (dctl),
    .a    (ua),
    .b    (ub),
    .band (band)
  );

  // Label store: one write, one registered read per cycle
  always_ff @(posedge clk) begin
    if (lbl_we) begin
      label_mem[lbl_waddr] <= lbl_wdata;
    end
    lq <= label_mem[lbl_raddr];
  end

  // helix wins over strand; only windows that fit the chain label their center
  always_comb begin
    win_lbl = bssa_pkg::SSE_COIL;
    if (i_r >= CW'(2) && i_e + EW'(3) < n_e) begin
      if (bssa_pkg::window_ok(fo2_r, fo1_r, cur_flags_r, 1'b0)) begin
        win_lbl = bssa_pkg::SSE_HELIX;
      end else if (bssa_pkg::window_ok(fo2_r, fo1_r, cur_flags_r, 1'b1)) begin
        win_lbl = bssa_pkg::SSE_STRAND;
      end
    end
  end

  // Sequencer: next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      bssa_pkg::ST_LOAD: begin
        if (in_acc && in_last_residue) begin
          state_nxt = (n_eff < CW'(bssa_pkg::MIN_RES)) ? bssa_pkg::ST_SHORT
                                                       : bssa_pkg::ST_D_RDI;
        end
      end
      bssa_pkg::ST_SHORT:   state_nxt = bssa_pkg::ST_O_WAIT;
      bssa_pkg::ST_D_RDI:   state_nxt = bssa_pkg::ST_D_LDI;
      bssa_pkg::ST_D_LDI:   state_nxt = bssa_pkg::ST_D_NEXTK;
      bssa_pkg::ST_D_NEXTK: begin
        if (k_r == 2'd3) begin
          state_nxt = bssa_pkg::ST_D_FIN;
        end else if (EW'(jpair) < n_e) begin
          state_nxt = bssa_pkg::ST_D_RDJ;
        end
      end
      bssa_pkg::ST_D_RDJ:   state_nxt = bssa_pkg::ST_D_SQX;
      bssa_pkg::ST_D_SQX:   state_nxt = bssa_pkg::ST_D_SQY;
      bssa_pkg::ST_D_SQY:   state_nxt = bssa_pkg::ST_D_SQZ;
      bssa_pkg::ST_D_SQZ:   state_nxt = bssa_pkg::ST_D_CMP;
      bssa_pkg::ST_D_CMP:   state_nxt = bssa_pkg::ST_D_NEXTK;
      bssa_pkg::ST_D_FIN: begin
        state_nxt = (i_e + EW'(1) == n_e) ? bssa_pkg::ST_R_RD0 : bssa_pkg::ST_D_RDI;
      end
      bssa_pkg::ST_R_RD0:   state_nxt = bssa_pkg::ST_R_INIT;
      bssa_pkg::ST_R_INIT:  state_nxt = bssa_pkg::ST_R_RD;
      bssa_pkg::ST_R_RD:    state_nxt = bssa_pkg::ST_R_EV;
      bssa_pkg::ST_R_EV: begin
        state_nxt = (i_e + EW'(1) == n_e) ? bssa_pkg::ST_R_END : bssa_pkg::ST_R_RD;
      end
      bssa_pkg::ST_R_END: begin
        state_nxt = (ns_r == '0) ? bssa_pkg::ST_T_RD2 : bssa_pkg::ST_F_LD;
      end
      bssa_pkg::ST_F_LD:    state_nxt = bssa_pkg::ST_F_DEC;
      bssa_pkg::ST_F_DEC: begin
        if (b_e >= a_e + EW'(3)) begin
          if (a_r != '0) begin
            state_nxt = bssa_pkg::ST_F_EXA;
          end else if (b_e + EW'(2) < n_e) begin
            state_nxt = bssa_pkg::ST_F_EXB;
          end else begin
            state_nxt = bssa_pkg::ST_F_NEXT;
          end
        end else begin
          state_nxt = bssa_pkg::ST_F_CLR;
        end
      end
      bssa_pkg::ST_F_EXA:   state_nxt = bssa_pkg::ST_F_EXA2;
      bssa_pkg::ST_F_EXA2: begin
        state_nxt = (b_e + EW'(2) < n_e) ? bssa_pkg::ST_F_EXB : bssa_pkg::ST_F_NEXT;
      end
      bssa_pkg::ST_F_EXB:   state_nxt = bssa_pkg::ST_F_EXB2;
      bssa_pkg::ST_F_EXB2:  state_nxt = bssa_pkg::ST_F_NEXT;
      bssa_pkg::ST_F_CLR: begin
        if (!(j_r < b_r && j_r < n_r)) begin
          state_nxt = bssa_pkg::ST_F_NEXT;
        end
      end
      bssa_pkg::ST_F_NEXT: begin
        state_nxt = (rk_r + RW'(1) == ns_r) ? bssa_pkg::ST_T_RD2 : bssa_pkg::ST_F_LD;
      end
      bssa_pkg::ST_T_RD2:   state_nxt = bssa_pkg::ST_T_RDN;
      bssa_pkg::ST_T_RDN:   state_nxt = bssa_pkg::ST_T_CAP;
      bssa_pkg::ST_T_CAP:   state_nxt = bssa_pkg::ST_O_RD;
      bssa_pkg::ST_O_RD:    state_nxt = bssa_pkg::ST_O_LD;
      bssa_pkg::ST_O_LD:    state_nxt = bssa_pkg::ST_O_WAIT;
      bssa_pkg::ST_O_WAIT: begin
        if (out_ready) begin
          state_nxt = last_r ? bssa_pkg::ST_LOAD : bssa_pkg::ST_O_RD;
        end
      end
      default:              state_nxt = bssa_pkg::ST_LOAD;
    endcase
  end

  // Sequencer: memory addresses, squarer control and label writes
  always_comb begin
    crd_addr  = i_r[IW-1:0];
    dctl      = '{clr: 1'b0, en: 1'b0, sep: k_r};
    ua        = ci_r.x;
    ub        = cq.x;
    lbl_we    = 1'b0;
    lbl_waddr = i_r[IW-1:0];
    lbl_wdata = bssa_pkg::SSE_COIL;
    lbl_raddr = i_r[IW-1:0];
    unique case (state_r)
      bssa_pkg::ST_D_RDJ: begin
        crd_addr = jpair[IW-1:0];
        dctl.clr = 1'b1;
      end
      bssa_pkg::ST_D_SQX: begin
        crd_addr = jpair[IW-1:0];
        dctl.en  = 1'b1;
      end
      bssa_pkg::ST_D_SQY: begin
        crd_addr = jpair[IW-1:0];
        dctl.en  = 1'b1;
        ua       = ci_r.y;
        ub       = cq.y;
      end
      bssa_pkg::ST_D_SQZ: begin
        crd_addr = jpair[IW-1:0];
        dctl.en  = 1'b1;
        ua       = ci_r.z;
        ub       = cq.z;
      end
      bssa_pkg::ST_D_FIN: begin
        lbl_we    = 1'b1;
        lbl_wdata = win_lbl;
      end
      bssa_pkg::ST_R_RD0: lbl_raddr = '0;
      bssa_pkg::ST_F_EXA: lbl_raddr = a_r[IW-1:0];
      bssa_pkg::ST_F_EXA2: begin
        lbl_we    = 1'b1;
        lbl_waddr = IW'(a_r - CW'(1));
        lbl_wdata = lq;
      end
      bssa_pkg::ST_F_EXB: lbl_raddr = IW'(b_r - CW'(1));
      bssa_pkg::ST_F_EXB2: begin
        lbl_we    = 1'b1;
        lbl_waddr = b_r[IW-1:0];
        lbl_wdata = lq;
      end
      bssa_pkg::ST_F_CLR: begin
        lbl_we    = j_r < b_r && j_r < n_r;
        lbl_waddr = j_r[IW-1:0];
      end
      bssa_pkg::ST_T_RD2: lbl_raddr = IW'(2);
      bssa_pkg::ST_T_RDN: lbl_raddr = IW'(n_r - CW'(3));
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= bssa_pkg::ST_LOAD;
      cnt_r    <= '0;
      ovf_r    <= 1'b0;
      ovalid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      unique case (state_r)
        bssa_pkg::ST_LOAD: begin
          if (in_acc) begin
            // drop residues beyond capacity, but remember it for the status
            if (in_last_residue) begin
              n_r    <= n_eff;
              stat_r <= (ovf_r || !fits) ? bssa_pkg::STAT_DROP : bssa_pkg::STAT_OK;
              cnt_r  <= '0;
              ovf_r  <= 1'b0;
              i_r    <= '0;
            end else begin
              cnt_r <= n_eff;
              ovf_r <= ovf_r || !fits;
            end
          end
        end
        bssa_pkg::ST_SHORT: begin
          idx_r    <= '0;
          code_r   <= bssa_pkg::SSE_COIL;
          ostat_r  <= bssa_pkg::STAT_SHORT;
          last_r   <= 1'b1;
          ovalid_r <= 1'b1;
        end
        bssa_pkg::ST_D_LDI: begin
          ci_r        <= cq;
          k_r         <= '0;
          cur_flags_r <= '0;
        end
        bssa_pkg::ST_D_NEXTK: begin
          if (k_r != 2'd3 && !(EW'(jpair) < n_e)) begin
            k_r <= k_r + 2'd1;
          end
        end
        bssa_pkg::ST_D_CMP: begin
          cur_flags_r[k_r]            <= band[0];
          cur_flags_r[3'd3 + 3'(k_r)] <= band[1];
          k_r                         <= k_r + 2'd1;
        end
        bssa_pkg::ST_D_FIN: begin
          fo2_r <= fo1_r;
          fo1_r <= cur_flags_r;
          i_r   <= i_r + CW'(1);
        end
        bssa_pkg::ST_R_INIT: begin
          prev_r <= lq;
          cur_r  <= bssa_pkg::SSE_COIL;
          i_r    <= CW'(1);
          ns_r   <= '0;
          ne_r   <= '0;
        end
        bssa_pkg::ST_R_EV: begin
          // a run opens where a non-coil label differs from its left neighbor
          if (lq != bssa_pkg::SSE_COIL && prev_r != lq) begin
            if (ns_r < RW'(MAX_RUNS)) begin
              run_starts[ns_r[RIW-1:0]] <= i_r;
              ns_r <= ns_r + RW'(1);
            end
            cur_r <= lq;
          end else if (lq != cur_r) begin
            if (ne_r < ns_r) begin
              run_ends[ne_r[RIW-1:0]] <= i_r;
              ne_r <= ne_r + RW'(1);
            end
            cur_r <= lq;
          end
          prev_r <= lq;
          i_r    <= i_r + CW'(1);
        end
        bssa_pkg::ST_R_END: begin
          if (ne_r < ns_r) begin
            run_ends[ne_r[RIW-1:0]] <= n_r;
            ne_r <= ne_r + RW'(1);
          end
          rk_r <= '0;
        end
        bssa_pkg::ST_F_LD: begin
          a_r <= run_starts[rk_r[RIW-1:0]];
          b_r <= run_ends[rk_r[RIW-1:0]];
        end
        bssa_pkg::ST_F_DEC:  j_r  <= a_r;
        bssa_pkg::ST_F_CLR:  j_r  <= j_r + CW'(1);
        bssa_pkg::ST_F_NEXT: rk_r <= rk_r + RW'(1);
        bssa_pkg::ST_T_RDN:  h_r  <= lq;
        bssa_pkg::ST_T_CAP: begin
          t_r <= lq;
          i_r <= '0;
        end
        bssa_pkg::ST_O_LD: begin
          // head and tail residues copy their inner neighbors
          idx_r <= 6'(i_r);
          if (i_r <= CW'(2)) begin
            code_r <= h_r;
          end else if (i_e + EW'(3) >= n_e) begin
            code_r <= t_r;
          end else begin
            code_r <= lq;
          end
          ostat_r  <= stat_r;
          last_r   <= (i_e + EW'(1) == n_e);
          ovalid_r <= 1'b1;
        end
        bssa_pkg::ST_O_WAIT: begin
          if (out_ready) begin
            ovalid_r <= 1'b0;
            i_r      <= i_r + CW'(1);
          end
        end
        default: ;
      endcase
    end
  end

  `BSSA_ASSERT_NEVER(a_no_overlap, in_ready && out_valid, "load while a result waits")
  `BSSA_ASSERT(a_last_reopens, (out_valid && out_ready && out_last_result) |=> in_ready, "no reload after final word")
  `BSSA_ASSERT(a_short_single, (out_valid && out_status == bssa_pkg::STAT_SHORT) |-> (out_last_result && out_residue_index == 6'd0), "short status word malformed")
  `BSSA_ASSERT(a_out_hold, (out_valid && !out_ready) |=> (out_valid && $stable(out_residue_index)), "word moved while held")

endmodule
